FILE: hw/rtl/csb_pkg.sv
package csb_pkg;

  localparam int MAX_SCREEN_COLS = 8192;
  localparam int MAX_SCREEN_ROWS = 4096;
  localparam int MAX_SPRITE_DIM  = 1024;

  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 96;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 14;

  localparam logic [7:0] PIX_TRANSPARENT = 8'd255;

  localparam logic signed [14:0] TRACK_LOW_INIT  = 15'sd10000;
  localparam logic signed [14:0] TRACK_HIGH_INIT = -15'sd10000;

  localparam logic REQ_COMMAND = 1'b0;
  localparam logic REQ_PIXEL   = 1'b1;

  localparam logic [CFG_INDEX_W-1:0] CFG_SCREEN_COLS = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SCREEN_ROWS = 1'b1;

  // Visible part of the current sprite, latched from a command.
  typedef struct packed {
    logic [12:0] dx;      // first visible destination column
    logic [11:0] dy;      // first visible destination row
    logic [10:0] sx;      // first visible source column
    logic [10:0] sy;      // first visible source row
    logic [10:0] w;       // visible width
    logic [10:0] h;       // visible height
    logic [10:0] height;  // source rows of the sprite
  } window_t;

endpackage

FILE: hw/rtl/clipped_sprite_blit.sv
// Clipped color-key sprite blitter. A command transfer (tuser 0) sets up a sprite, clipped
// against the screen size; pixel transfers (tuser 1) then stream in raster order and each
// gives one result transfer carrying an optional framebuffer write (result tuser 1), the
// end-of-blit mark on tlast and the running row and start-column extremes. Every input
// transfer, command or pixel, produces exactly one result in the next cycle. The block takes
// one item per cycle: all work sits between the input handshake and a single output
// register, and input ready drops only while that register holds a result not yet taken.
// Screen size registers are written on the cfg channel, which is always ready.
module clipped_sprite_blit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // pos_x[13:0], pos_y[27:14], src_width[38:28], src_height[49:39], row_pitch[60:50],
  // mirror[61], pixel_value[69:62], zero fill [71:70]
  input  logic [csb_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // req_type[0]
  input  logic                                s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // dest_col[12:0], dest_row[24:13], write_value[32:25], min_row_seen[47:33],
  // max_row_seen[62:48], min_col_seen[77:63], max_col_seen[92:78], zero fill [95:93]
  output logic [csb_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  // write_valid[0]
  output logic                                m_axis_tuser,
  // blit_done
  output logic                                m_axis_tlast,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [csb_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [csb_pkg::CFG_DATA_W-1:0]      cfg_data
);

  logic [13:0]        screen_cols;
  logic [12:0]        screen_rows;
  logic               clip_active;
  csb_pkg::window_t   clip_window;
  logic               mirror_flag;
  logic [10:0]        pitch_reg;
  logic [10:0]        src_col_count;
  logic [10:0]        src_row_count;
  logic signed [14:0] low_row_track;
  logic signed [14:0] high_row_track;
  logic signed [14:0] low_col_track;
  logic signed [14:0] high_col_track;
  logic signed [14:0] low_row_track_next;
  logic signed [14:0] high_row_track_next;
  logic signed [14:0] low_col_track_next;
  logic signed [14:0] high_col_track_next;

  logic               out_write;
  logic [12:0]        out_col;
  logic [11:0]        out_row;
  logic [7:0]         out_value;
  logic               out_done;

  logic               in_xfer;
  logic               cfg_xfer;
  logic               is_cmd;

  // Command decode and clipping.
  logic [13:0]        pos_x;
  logic [13:0]        pos_y;
  logic [10:0]        src_width;
  logic [10:0]        src_height;
  logic [10:0]        row_pitch;
  logic               mirror;
  logic [7:0]         pixel_value;
  logic [13:0]        scw;
  logic [12:0]        scr;
  logic [10:0]        width_sat;
  logic [10:0]        height_sat;
  logic [10:0]        pitch_eff;
  logic signed [15:0] x_ext, y_ext;
  logic signed [15:0] x_end, y_end;
  logic signed [15:0] scw_ext, scr_ext;
  logic signed [15:0] left, top, right, bottom;
  logic signed [15:0] span_w, span_h;
  logic signed [15:0] skip_x, skip_y;
  logic               cmd_ok;

  // Pixel path.
  logic [11:0]        rr;
  logic [11:0]        cc;
  logic               row_vis;
  logic               col_vis;
  logic [10:0]        w_m1;
  logic [10:0]        mcol;
  logic [11:0]        drow;
  logic [12:0]        dcol;
  logic [12:0]        scol;
  logic signed [14:0] drow_s;
  logic signed [14:0] scol_s;
  logic               pix_act;
  logic               row_start;
  logic               pix_write;
  logic               col_wrap;
  logic               row_last;

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign cfg_ready     = 1'b1;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign cfg_xfer      = cfg_valid && cfg_ready;
  assign is_cmd        = (s_axis_tuser == csb_pkg::REQ_COMMAND);

  assign pos_x       = s_axis_tdata[13:0];
  assign pos_y       = s_axis_tdata[27:14];
  assign src_width   = s_axis_tdata[38:28];
  assign src_height  = s_axis_tdata[49:39];
  assign row_pitch   = s_axis_tdata[60:50];
  assign mirror      = s_axis_tdata[61];
  assign pixel_value = s_axis_tdata[69:62];

  always_comb begin
    scw = (screen_cols > 14'(csb_pkg::MAX_SCREEN_COLS)) ?
          14'(csb_pkg::MAX_SCREEN_COLS) : screen_cols;
    scr = (screen_rows > 13'(csb_pkg::MAX_SCREEN_ROWS)) ?
          13'(csb_pkg::MAX_SCREEN_ROWS) : screen_rows;
    width_sat  = (src_width > 11'(csb_pkg::MAX_SPRITE_DIM)) ?
                 11'(csb_pkg::MAX_SPRITE_DIM) : src_width;
    height_sat = (src_height > 11'(csb_pkg::MAX_SPRITE_DIM)) ?
                 11'(csb_pkg::MAX_SPRITE_DIM) : src_height;
    if (row_pitch == 11'd0) begin
      pitch_eff = width_sat;
    end else if (row_pitch > 11'(csb_pkg::MAX_SPRITE_DIM)) begin
      pitch_eff = 11'(csb_pkg::MAX_SPRITE_DIM);
    end else begin
      pitch_eff = row_pitch;
    end

    x_ext   = $signed({{2{pos_x[13]}}, pos_x});
    y_ext   = $signed({{2{pos_y[13]}}, pos_y});
    x_end   = x_ext + $signed({5'd0, width_sat});
    y_end   = y_ext + $signed({5'd0, height_sat});
    scw_ext = $signed({2'd0, scw});
    scr_ext = $signed({3'd0, scr});
    left    = pos_x[13] ? 16'sd0 : x_ext;
    top     = pos_y[13] ? 16'sd0 : y_ext;
    right   = (x_end < scw_ext) ? x_end : scw_ext;
    bottom  = (y_end < scr_ext) ? y_end : scr_ext;
    span_w  = right - left;
    span_h  = bottom - top;
    skip_x  = left - x_ext;
    skip_y  = top - y_ext;
    cmd_ok  = (span_w > 16'sd0) && (span_h > 16'sd0) && (pitch_eff != 11'd0);
  end

  always_comb begin
    rr      = {1'b0, src_row_count} - {1'b0, clip_window.sy};
    cc      = {1'b0, src_col_count} - {1'b0, clip_window.sx};
    row_vis = !rr[11] && (rr[10:0] < clip_window.h);
    col_vis = !cc[11] && (cc[10:0] < clip_window.w);
    w_m1    = clip_window.w - 11'd1;
    mcol    = mirror_flag ? (w_m1 - cc[10:0]) : cc[10:0];
    drow    = clip_window.dy + {1'b0, rr[10:0]};
    dcol    = clip_window.dx + {2'd0, mcol};
    // A mirrored row starts at its last visible column.
    scol    = clip_window.dx + (mirror_flag ? {2'd0, w_m1} : 13'd0);
    drow_s  = $signed({3'd0, drow});
    scol_s  = $signed({2'd0, scol});

    pix_act   = in_xfer && !is_cmd && clip_active;
    row_start = pix_act && row_vis && (src_col_count == 11'd0);
    pix_write = pix_act && row_vis && col_vis && (pixel_value != csb_pkg::PIX_TRANSPARENT);
    col_wrap  = ({1'b0, src_col_count} + 12'd1) >= {1'b0, pitch_reg};
    row_last  = ({1'b0, src_row_count} + 12'd1) >= {1'b0, clip_window.height};

    low_row_track_next  = low_row_track;
    high_row_track_next = high_row_track;
    low_col_track_next  = low_col_track;
    high_col_track_next = high_col_track;
    if (row_start) begin
      if (drow_s < low_row_track) begin
        low_row_track_next = drow_s;
      end
      if (drow_s > high_row_track) begin
        high_row_track_next = drow_s;
      end
      if (scol_s < low_col_track) begin
        low_col_track_next = scol_s;
      end
      if (scol_s > high_col_track) begin
        high_col_track_next = scol_s;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_cols    <= 14'd200;
      screen_rows    <= 13'd200;
      clip_active    <= 1'b0;
      src_col_count  <= 11'd0;
      src_row_count  <= 11'd0;
      low_row_track  <= csb_pkg::TRACK_LOW_INIT;
      high_row_track <= csb_pkg::TRACK_HIGH_INIT;
      low_col_track  <= csb_pkg::TRACK_LOW_INIT;
      high_col_track <= csb_pkg::TRACK_HIGH_INIT;
      m_axis_tvalid  <= 1'b0;
    end else begin
      if (cfg_xfer) begin
        case (cfg_index)
          csb_pkg::CFG_SCREEN_COLS: screen_cols <= cfg_data;
          csb_pkg::CFG_SCREEN_ROWS: screen_rows <= cfg_data[12:0];
          default: ;
        endcase
      end
      if (in_xfer && is_cmd) begin
        clip_active   <= cmd_ok;
        src_col_count <= 11'd0;
        src_row_count <= 11'd0;
      end else if (pix_act) begin
        if (col_wrap) begin
          src_col_count <= 11'd0;
          if (row_last) begin
            clip_active   <= 1'b0;
            src_row_count <= 11'd0;
          end else begin
            src_row_count <= src_row_count + 11'd1;
          end
        end else begin
          src_col_count <= src_col_count + 11'd1;
        end
      end
      low_row_track  <= low_row_track_next;
      high_row_track <= high_row_track_next;
      low_col_track  <= low_col_track_next;
      high_col_track <= high_col_track_next;
      if (in_xfer) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && is_cmd && cmd_ok) begin
      clip_window.dx     <= left[12:0];
      clip_window.dy     <= top[11:0];
      clip_window.sx     <= skip_x[10:0];
      clip_window.sy     <= skip_y[10:0];
      clip_window.w      <= span_w[10:0];
      clip_window.h      <= span_h[10:0];
      clip_window.height <= height_sat;
      mirror_flag        <= mirror;
      pitch_reg          <= pitch_eff;
    end
    if (in_xfer) begin
      out_write <= pix_write;
      out_col   <= pix_write ? dcol : 13'd0;
      out_row   <= pix_write ? drow : 12'd0;
      out_value <= pix_write ? pixel_value : 8'd0;
      out_done  <= pix_act && col_wrap && row_last;
    end
  end

  // The extremes only move on an input transfer, which cannot happen while a result waits.
  assign m_axis_tdata = {3'd0, high_col_track, low_col_track, high_row_track, low_row_track,
                         out_value, out_row, out_col};
  assign m_axis_tuser = out_write;
  assign m_axis_tlast = out_done;

  a_ready_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with empty output register");

  a_no_write_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[32:0] == 33'd0))
    else $error("write fields nonzero without a write");

  a_done_ends_blit: assert property (@(posedge clk) disable iff (rst)
    (pix_act && col_wrap && row_last) |=> (!clip_active && src_row_count == 11'd0))
    else $error("blit still active after its last pixel");

  a_rows_ordered: assert property (@(posedge clk) disable iff (rst)
    (low_row_track != csb_pkg::TRACK_LOW_INIT) |-> (low_row_track <= high_row_track))
    else $error("row extremes out of order");

endmodule
